FILE: design/lphs_pkg.sv
package lphs_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_IDX_W = 4;

  // Default number of slots
  localparam int unsigned TABLE_SIZE = 16;

  // Key bits folded into the home-slot remainder per cycle
  localparam int unsigned HASH_BITS  = 8;

  // Command codes (code 3 is unused and answers not found)
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
  } rsp_t;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: design/lphs_ram.sv
module lphs_ram #(
  parameter int unsigned Width = lphs_pkg::ENTRY_W,
  parameter int unsigned Depth = lphs_pkg::TABLE_SIZE
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lphs_hash.sv
module lphs_hash #(
  parameter int unsigned TableSize = lphs_pkg::TABLE_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lphs_pkg::KEY_W-1:0]   key_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] home_o
);

  localparam int unsigned AW    = $clog2(TableSize);
  localparam int unsigned Steps = lphs_pkg::KEY_W / lphs_pkg::HASH_BITS;
  localparam int unsigned SW    = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [AW:0]    Modulus  = (AW+1)'(TableSize);
  localparam logic [SW-1:0]  LastStep = SW'(Steps - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [SW-1:0]              cnt_q, cnt_d;
  logic [lphs_pkg::KEY_W-1:0] key_q, key_d;
  logic [AW-1:0]              rem_q, rem_d;
  logic [AW-1:0]              rem_nxt;
  logic [AW:0]                trial;

  // long division, MSB first: rem = (2*rem + bit) mod TableSize per bit
  always_comb begin
    rem_nxt = rem_q;
    trial   = '0;
    for (int i = 0; i < int'(lphs_pkg::HASH_BITS); i++) begin
      trial = {rem_nxt, key_q[lphs_pkg::KEY_W-1-i]};
      if (trial >= Modulus) begin
        trial = trial - Modulus;
      end
      rem_nxt = trial[AW-1:0];
    end
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_nxt;
      key_d = key_q << lphs_pkg::HASH_BITS;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign home_o = rem_q;

endmodule

FILE: design/linear_probe_hash_set_core.sv
// Hash set of 32-bit keys with open addressing and linear probing over TableSize slots,
// each slot a valid bit plus key held in one single-port-read slot memory. The home slot
// is key mod TableSize, found by a remainder unit that folds 8 key bits per cycle. Insert
// takes the first empty slot from home, delete clears the first matching slot, search
// reports it; duplicates are allowed and a miss walks the whole ring. The probe streams
// one memory read per cycle; the unused command answers "not found". slot_index carries
// the low 4 bits of the slot number and is zero on full or not found. After reset a
// clearing pass writes every slot empty, during which req_stall_o stays high. One
// request is worked at a time; the response register lets the next request in while a
// response still waits on rsp_stall_i.
module linear_probe_hash_set_core #(
  parameter int unsigned TableSize = lphs_pkg::TABLE_SIZE
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  lphs_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output lphs_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(TableSize);
  localparam int unsigned CW = $clog2(TableSize + 1);
  localparam logic [AW-1:0] LastIdx = AW'(TableSize - 1);
  localparam logic [CW-1:0] CntLast = CW'(TableSize - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [AW-1:0]                   clr_ptr_q, clr_ptr_d;
  logic [lphs_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [lphs_pkg::KEY_W-1:0]      key_q, key_d;
  logic [AW-1:0]                   ptr_q, ptr_d;
  logic [CW-1:0]                   issued_q, issued_d;
  logic                            chk_v_q, chk_v_d;
  logic [AW-1:0]                   chk_ptr_q, chk_ptr_d;
  logic                            chk_last_q, chk_last_d;
  lphs_pkg::rsp_t                  res_q, res_d;
  logic                            rsp_valid_q, rsp_valid_d;
  lphs_pkg::rsp_t                  rsp_q, rsp_d;

  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr;
  lphs_pkg::entry_t                mem_wdata;
  logic [lphs_pkg::ENTRY_W-1:0]    mem_rdata;
  lphs_pkg::entry_t                rd_entry;

  logic                            hash_start, hash_done;
  logic [AW-1:0]                   hash_home;
  logic                            want_empty, hit;

  lphs_hash #(
    .TableSize(TableSize)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (req_i.key_in),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  lphs_ram #(
    .Width(lphs_pkg::ENTRY_W),
    .Depth(TableSize)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(ptr_q),
    .rdata_o(mem_rdata)
  );

  // probe compare on the entry read last cycle
  assign rd_entry   = lphs_pkg::entry_t'(mem_rdata);
  assign want_empty = (cmd_q == lphs_pkg::CMD_INSERT);
  assign hit = chk_v_q && (want_empty ? !rd_entry.valid
                                      : (rd_entry.valid && (rd_entry.key == key_q)));

  // control
  always_comb begin
    state_d     = state_q;
    clr_ptr_d   = clr_ptr_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    ptr_d       = ptr_q;
    issued_d    = issued_q;
    chk_v_d     = chk_v_q;
    chk_ptr_d   = chk_ptr_q;
    chk_last_d  = chk_last_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = chk_ptr_q;
    mem_wdata   = '0;
    hash_start  = 1'b0;

    // response taken downstream
    if (rsp_valid_q && !rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        clr_ptr_d = clr_ptr_q + 1'b1;
        if (clr_ptr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d = req_i.cmd;
          key_d = req_i.key_in;
          if (req_i.cmd == lphs_pkg::CMD_INSERT || req_i.cmd == lphs_pkg::CMD_DELETE ||
              req_i.cmd == lphs_pkg::CMD_SEARCH) begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end else begin
            res_d.status     = lphs_pkg::ST_NOT_FOUND;
            res_d.slot_index = '0;
            state_d          = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          ptr_d    = hash_home;
          issued_d = '0;
          chk_v_d  = 1'b0;
          state_d  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit) begin
          // update the slot on insert or delete and report it
          res_d.slot_index = lphs_pkg::SLOT_IDX_W'(chk_ptr_q);
          if (cmd_q == lphs_pkg::CMD_INSERT) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_q;
            res_d.status    = lphs_pkg::ST_INSERTED;
          end else if (cmd_q == lphs_pkg::CMD_DELETE) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
            mem_wdata.key   = key_q;
            res_d.status    = lphs_pkg::ST_DELETED;
          end else begin
            res_d.status    = lphs_pkg::ST_FOUND;
          end
          chk_v_d = 1'b0;
          state_d = S_DONE;
        end else if (chk_v_q && chk_last_q) begin
          // whole ring visited
          res_d.status     = want_empty ? lphs_pkg::ST_FULL : lphs_pkg::ST_NOT_FOUND;
          res_d.slot_index = '0;
          chk_v_d          = 1'b0;
          state_d          = S_DONE;
        end else begin
          // issue next slot read, wrapping around the ring
          mem_re     = 1'b1;
          chk_v_d    = 1'b1;
          chk_ptr_d  = ptr_q;
          chk_last_d = (issued_q == CntLast);
          ptr_d      = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
          issued_d   = issued_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      issued_q    <= '0;
      chk_v_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_ptr_q   <= clr_ptr_d;
      issued_q    <= issued_d;
      chk_v_q     <= chk_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    ptr_q      <= ptr_d;
    chk_ptr_q  <= chk_ptr_d;
    chk_last_q <= chk_last_d;
    res_q      <= res_d;
    rsp_q      <= rsp_d;
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: design/lphs_checker.sv
module lphs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_stall_o,
  input lphs_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_stall_i,
  input lphs_pkg::rsp_t rsp_o
);

  // a stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

  // one request at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("request accepted while previous one in flight");

  // a new response only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(req_stall_o))
    else $error("response appeared without work in progress");

  // full and not-found report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == lphs_pkg::ST_FULL ||
                    rsp_o.status == lphs_pkg::ST_NOT_FOUND) |-> rsp_o.slot_index == '0)
    else $error("miss response with nonzero slot index");

endmodule

bind linear_probe_hash_set_core lphs_checker u_lphs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o),
  .req_i      (req_i),
  .rsp_valid_o(rsp_valid_o),
  .rsp_stall_i(rsp_stall_i),
  .rsp_o      (rsp_o)
);
